[src/asm_pkg.sv]
// ----------------------------------------------------------------------------
// asm_pkg: shared types and constants for the alignment seed merger
// Sequencer states, control bundle, function codes and score limits.
// ----------------------------------------------------------------------------
package asm_pkg;

  localparam logic FUNC_MERGE   = 1'b0;
  localparam logic FUNC_REPLACE = 1'b1;

  localparam int PART_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int MUL_STEPS = 4;

  localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SCORE_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BOX,
    S_SIZE,
    S_WEIGHT,
    S_MUL,
    S_FIX,
    S_DIV,
    S_SAT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic box;
    logic size;
    logic weight;
    logic mul;
    logic fix;
    logic div;
    logic sat;
    logic emit;
  } ctl_t;

endpackage

[src/alignment_seed_merger.sv]
// Flow: a replace item is loaded into the held seed on acceptance and goes
// straight to output; a merge item steps through box, size, weight, products,
// fix-up, the 32-step divider, saturate and output, or skips from weight to
// output when the merged size is zero; a new item waits for the emit.
// Reset: synchronous active-low rst_n clears the held seed to zero and idles.
// ----------------------------------------------------------------------------
// alignment_seed_merger: holds one alignment seed and merges input seeds
// Union box, widest diagonal band, size-weighted score via one shared adder,
// a 32x32 multiplier and a restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
module alignment_seed_merger #(
  parameter int POS_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [31:0]        in_begin_h,
  input  logic [31:0]        in_begin_v,
  input  logic [31:0]        in_end_h,
  input  logic [31:0]        in_end_v,
  input  logic signed [32:0] in_lower_diag,
  input  logic signed [32:0] in_upper_diag,
  input  logic signed [31:0] in_score,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_begin_h,
  output logic [31:0]        out_begin_v,
  output logic [31:0]        out_end_h,
  output logic [31:0]        out_end_v,
  output logic signed [32:0] out_lower_diag,
  output logic signed [32:0] out_upper_diag,
  output logic signed [31:0] out_score
);

  localparam int PW    = POS_BITS;
  localparam int DW    = POS_BITS + 1;
  localparam int AW    = POS_BITS + 1;
  localparam int ACC_W = POS_BITS + 35;
  localparam int EXT_W = ACC_W + 2 * asm_pkg::PART_W;
  localparam int PH    = asm_pkg::PART_W;

  function automatic logic [PW-1:0] ext_len(input logic [PW-1:0] b, input logic [PW-1:0] e);
    return (e >= b) ? e - b : '0;
  endfunction

  function automatic logic [PW-1:0] seed_size(input logic [PW-1:0] bh, input logic [PW-1:0] bv,
                                              input logic [PW-1:0] eh, input logic [PW-1:0] ev);
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    x = ext_len(bh, eh);
    y = ext_len(bv, ev);
    return (x > y) ? x : y;
  endfunction

  asm_pkg::state_t state_r, state_nxt;
  asm_pkg::ctl_t   ctl;

  logic [4:0] step_r, step_nxt;

  logic [PW-1:0] held_bh_r, held_bv_r, held_eh_r, held_ev_r;
  logic [DW-1:0] held_ld_r, held_ud_r;
  logic [31:0]   held_sc_r;

  logic [PW-1:0] inp_bh_r, inp_bv_r, inp_eh_r, inp_ev_r;
  logic [DW-1:0] inp_ld_r, inp_ud_r;
  logic [31:0]   inp_sc_r;

  logic [PW-1:0] s1_r, s2_r, n_r;
  logic [AW-1:0] a_r, b_r;

  logic [2*PH-1:0] prod_r;
  logic            prod_hi_r, prod_neg_r;
  logic [ACC_W-1:0] acc_r;
  logic             sign_r;
  logic [AW-1:0]    rem_r;
  logic [31:0]      quo_r;

  logic        out_valid_r;
  logic [31:0] out_bh_r, out_bv_r, out_eh_r, out_ev_r, out_sc_r;
  logic [32:0] out_ld_r, out_ud_r;

  logic [PW-1:0] in_bh, in_bv, in_eh, in_ev;
  logic [DW-1:0] in_ld, in_ud;

  assign in_bh = PW'(in_begin_h);
  assign in_bv = PW'(in_begin_v);
  assign in_eh = PW'(in_end_h);
  assign in_ev = PW'(in_end_v);
  assign in_ld = DW'(in_lower_diag);
  assign in_ud = DW'(in_upper_diag);

  logic out_free;
  logic n_zero;
  logic div_last;
  logic mul_last;

  assign out_free = !out_valid_r || !out_stall;
  assign n_zero   = (n_r == '0);
  assign div_last = (step_r == 5'(asm_pkg::DIV_STEPS - 1));
  assign mul_last = (step_r == 5'(asm_pkg::MUL_STEPS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      asm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == asm_pkg::FUNC_REPLACE) ? asm_pkg::S_DONE : asm_pkg::S_BOX;
        end
      end
      asm_pkg::S_BOX:    state_nxt = asm_pkg::S_SIZE;
      asm_pkg::S_SIZE:   state_nxt = asm_pkg::S_WEIGHT;
      asm_pkg::S_WEIGHT: state_nxt = n_zero ? asm_pkg::S_DONE : asm_pkg::S_MUL;
      asm_pkg::S_MUL: begin
        if (mul_last) state_nxt = asm_pkg::S_FIX;
      end
      asm_pkg::S_FIX:    state_nxt = asm_pkg::S_DIV;
      asm_pkg::S_DIV: begin
        if (div_last) state_nxt = asm_pkg::S_SAT;
      end
      asm_pkg::S_SAT:    state_nxt = asm_pkg::S_DONE;
      asm_pkg::S_DONE: begin
        if (out_free) state_nxt = asm_pkg::S_IDLE;
      end
      default:           state_nxt = asm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      asm_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      asm_pkg::S_BOX:    ctl.box    = 1'b1;
      asm_pkg::S_SIZE:   ctl.size   = 1'b1;
      asm_pkg::S_WEIGHT: ctl.weight = 1'b1;
      asm_pkg::S_MUL:    ctl.mul    = 1'b1;
      asm_pkg::S_FIX:    ctl.fix    = 1'b1;
      asm_pkg::S_DIV:    ctl.div    = 1'b1;
      asm_pkg::S_SAT:    ctl.sat    = 1'b1;
      asm_pkg::S_DONE:   ctl.emit   = out_free;
      default:           ctl        = '0;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if (ctl.mul && !mul_last) step_nxt = step_r + 5'd1;
    if (ctl.div && !div_last) step_nxt = step_r + 5'd1;
  end

  // shared multiplier operands
  logic [2*PH-1:0] a_ext, b_ext, wsel;
  logic [PH-1:0]   m1, m2, part, msel;
  assign a_ext = (2*PH)'(a_r);
  assign b_ext = (2*PH)'(b_r);
  assign m1    = held_sc_r[31] ? (~held_sc_r + 32'd1) : held_sc_r;
  assign m2    = inp_sc_r[31]  ? (~inp_sc_r + 32'd1)  : inp_sc_r;
  assign wsel  = step_r[1] ? b_ext : a_ext;
  assign part  = step_r[0] ? wsel[2*PH-1:PH] : wsel[PH-1:0];
  assign msel  = step_r[1] ? m2 : m1;

  // shared wide adder
  logic [EXT_W-1:0] pp_ext, pp_sh;
  logic [ACC_W-1:0] term, add_a, add_b, add_sum;
  logic             add_cin;
  assign pp_ext = EXT_W'(prod_r);
  assign pp_sh  = prod_hi_r ? {pp_ext[EXT_W-PH-1:0], {PH{1'b0}}} : pp_ext;
  assign term   = pp_sh[ACC_W-1:0];

  always_comb begin
    if (ctl.fix) begin
      add_a   = acc_r[ACC_W-1] ? ~acc_r : acc_r;
      add_b   = ACC_W'(n_r);
      add_cin = acc_r[ACC_W-1];
    end else begin
      add_a   = acc_r;
      add_b   = prod_neg_r ? ~term : term;
      add_cin = prod_neg_r;
    end
  end
  assign add_sum = add_a + add_b + ACC_W'(add_cin);

  // divider step
  logic [AW-1:0] dvs;
  logic [AW:0]   trial, trial_sub;
  logic          ge;
  assign dvs       = {n_r, 1'b0};
  assign trial     = {rem_r, quo_r[31]};
  assign ge        = (trial >= {1'b0, dvs});
  assign trial_sub = trial - {1'b0, dvs};

  logic [31:0] sat_score;
  always_comb begin
    if (sign_r) begin
      sat_score = (quo_r > asm_pkg::SCORE_MIN) ? asm_pkg::SCORE_MIN : (~quo_r + 32'd1);
    end else begin
      sat_score = quo_r[31] ? asm_pkg::SCORE_MAX : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= asm_pkg::S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      held_bh_r   <= '0;
      held_bv_r   <= '0;
      held_eh_r   <= '0;
      held_ev_r   <= '0;
      held_ld_r   <= '0;
      held_ud_r   <= '0;
      held_sc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.accept && in_func == asm_pkg::FUNC_REPLACE) begin
        held_bh_r <= in_bh;
        held_bv_r <= in_bv;
        held_eh_r <= in_eh;
        held_ev_r <= in_ev;
        held_ld_r <= in_ld;
        held_ud_r <= in_ud;
        held_sc_r <= in_score;
      end
      if (ctl.box) begin
        if (inp_bh_r < held_bh_r) held_bh_r <= inp_bh_r;
        if (inp_bv_r < held_bv_r) held_bv_r <= inp_bv_r;
        if (inp_eh_r > held_eh_r) held_eh_r <= inp_eh_r;
        if (inp_ev_r > held_ev_r) held_ev_r <= inp_ev_r;
        if ($signed(inp_ld_r) < $signed(held_ld_r)) held_ld_r <= inp_ld_r;
        if ($signed(inp_ud_r) > $signed(held_ud_r)) held_ud_r <= inp_ud_r;
      end
      if (ctl.weight && n_zero) held_sc_r <= '0;
      if (ctl.sat) held_sc_r <= sat_score;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      inp_bh_r <= in_bh;
      inp_bv_r <= in_bv;
      inp_eh_r <= in_eh;
      inp_ev_r <= in_ev;
      inp_ld_r <= in_ld;
      inp_ud_r <= in_ud;
      inp_sc_r <= in_score;
    end
    if (ctl.box) begin
      s1_r <= seed_size(held_bh_r, held_bv_r, held_eh_r, held_ev_r);
      s2_r <= seed_size(inp_bh_r, inp_bv_r, inp_eh_r, inp_ev_r);
    end
    if (ctl.size) begin
      n_r <= seed_size(held_bh_r, held_bv_r, held_eh_r, held_ev_r);
    end
    if (ctl.weight) begin
      a_r   <= AW'(n_r) + AW'(s1_r) - AW'(s2_r);
      b_r   <= AW'(n_r) + AW'(s2_r) - AW'(s1_r);
      acc_r <= '0;
    end
    if (ctl.mul) begin
      prod_r     <= part * msel;
      prod_hi_r  <= step_r[0];
      prod_neg_r <= step_r[1] ? inp_sc_r[31] : held_sc_r[31];
      if (step_r != '0) acc_r <= add_sum;
    end
    if (ctl.fix) begin
      sign_r <= acc_r[ACC_W-1];
      rem_r  <= add_sum[AW+31:32];
      quo_r  <= add_sum[31:0];
    end
    if (ctl.div) begin
      rem_r <= ge ? trial_sub[AW-1:0] : trial[AW-1:0];
      quo_r <= {quo_r[30:0], ge};
    end
    if (ctl.emit) begin
      out_bh_r <= 32'(held_bh_r);
      out_bv_r <= 32'(held_bv_r);
      out_eh_r <= 32'(held_eh_r);
      out_ev_r <= 32'(held_ev_r);
      out_ld_r <= 33'(held_ld_r);
      out_ud_r <= 33'(held_ud_r);
      out_sc_r <= held_sc_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_begin_h    = out_bh_r;
  assign out_begin_v    = out_bv_r;
  assign out_end_h      = out_eh_r;
  assign out_end_v      = out_ev_r;
  assign out_lower_diag = out_ld_r;
  assign out_upper_diag = out_ud_r;
  assign out_score      = out_sc_r;

endmodule

[src/asm_checker.sv]
// ----------------------------------------------------------------------------
// asm_checker: port-level checks for the alignment seed merger
// Output handshake hold, one item in flight, and replace pass-through.
// ----------------------------------------------------------------------------
module asm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_func,
  input logic signed [31:0] in_score,
  input logic               out_valid,
  input logic               out_stall,
  input logic [31:0]        out_begin_h,
  input logic [31:0]        out_begin_v,
  input logic [31:0]        out_end_h,
  input logic [31:0]        out_end_v,
  input logic signed [32:0] out_lower_diag,
  input logic signed [32:0] out_upper_diag,
  input logic signed [31:0] out_score
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_score) && $stable(out_begin_h)
                               && $stable(out_begin_v) && $stable(out_end_h)
                               && $stable(out_end_v) && $stable(out_lower_diag)
                               && $stable(out_upper_diag))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_replace: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func ##1 (!out_valid || !out_stall)
    |=> out_valid && out_score == $past(in_score, 2))
    else $error("replace item not passed through");

endmodule

bind alignment_seed_merger asm_checker u_asm_checker (.*);
